// ===== src/utf8_to_utf16_strict_decoder_macros.svh =====
// assertion helpers for the utf-8 to utf-16 decoder
`ifndef UTF8_TO_UTF16_STRICT_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_STRICT_DECODER_MACROS_SVH

// condition holds at every clock edge out of reset
`define U8U16_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/u8u16_pkg.sv =====
package u8u16_pkg;

    localparam int unsigned MAX_UNITS_DEFAULT = 4096;
    localparam int unsigned CAP_W             = 12;
    localparam logic [CAP_W-1:0] CAP_RESET    = 12'hFFF;
    localparam int unsigned MAX_GROUP         = 4;

    localparam logic [15:0] UNIT_QMARK   = 16'h003F;
    localparam logic [15:0] UNIT_TERM    = 16'h0000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] CODE_MAX     = 21'h10FFFF;
    localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
    localparam logic [20:0] SURR_LOW     = 21'h00D800;
    localparam logic [20:0] SURR_HIGH    = 21'h00DFFF;
    localparam logic [20:0] MIN_LEN2     = 21'h000080;
    localparam logic [20:0] MIN_LEN3     = 21'h000800;
    localparam logic [20:0] MIN_LEN4     = 21'h010000;

    typedef struct packed {
        logic [20:0] partial;
        logic [2:0]  needed;
        logic [1:0]  seen;
        logic        stopped;
    } dec_state_t;

    typedef struct packed {
        logic [2:0]                count;
        logic [MAX_GROUP-1:0][15:0] units;
    } unit_group_t;

endpackage

// ===== src/u8u16_step.sv =====
module u8u16_step
    import u8u16_pkg::*;
#(
    parameter int unsigned UW = $clog2(MAX_UNITS_DEFAULT)
) (
    input  dec_state_t    st,
    input  logic [UW-1:0] uw,
    input  logic [UW-1:0] cap,
    input  logic [7:0]    text_byte,
    output dec_state_t    st_next,
    output logic [UW-1:0] uw_next,
    output unit_group_t   group
);

    logic [UW-1:0] room;
    logic [2:0]    room3;
    logic          open_seq;
    logic          is_cont;
    logic [20:0]   code;
    logic [1:0]    seen_inc;
    logic          done;
    logic [20:0]   code_min;
    logic          bad_code;
    logic [20:0]   code_off;

    assign room     = (uw >= cap) ? '0 : cap - uw;
    assign room3    = (17'(room) >= 17'd4) ? 3'd4 : 3'(room);
    assign open_seq = (st.needed != 3'd0) && !st.stopped;
    assign is_cont  = (text_byte[7:6] == 2'b10);
    assign code     = {st.partial[14:0], text_byte[5:0]};
    assign seen_inc = st.seen + 2'd1;
    assign done     = ({1'b0, seen_inc} + 3'd1) >= st.needed;
    assign code_off = code - MIN_LEN4;

    always_comb
    begin
        case (st.needed)
            3'd2:    code_min = MIN_LEN2;
            3'd3:    code_min = MIN_LEN3;
            default: code_min = MIN_LEN4;
        endcase
    end

    assign bad_code = (code < code_min) || (code > CODE_MAX)
                   || ((code >= SURR_LOW) && (code <= SURR_HIGH));

    always_comb
    begin
        logic [2:0] bad_cnt;
        logic [2:0] n;
        logic       stop;
        logic       want_single;
        logic       want_pair;
        logic       want_fresh;

        st_next     = st;
        uw_next     = uw;
        group.units = '0;
        bad_cnt     = 3'd0;
        n           = 3'd0;
        stop        = st.stopped;
        want_single = 1'b0;
        want_pair   = 1'b0;
        want_fresh  = 1'b0;

        if (open_seq && is_cont)
        begin
            st_next.partial = code;
            st_next.seen    = seen_inc;
            if (done)
            begin
                st_next.needed  = 3'd0;
                st_next.seen    = 2'd0;
                st_next.partial = '0;
                if (bad_code)
                    bad_cnt = st.needed;
                else if (code > BMP_MAX)
                    want_pair = 1'b1;
                else
                    want_single = 1'b1;
            end
        end
        else
        begin
            if (open_seq)
            begin
                bad_cnt         = 3'd1 + {1'b0, st.seen};
                st_next.needed  = 3'd0;
                st_next.seen    = 2'd0;
                st_next.partial = '0;
            end
            want_fresh = 1'b1;
        end

        // held bytes flushed as question marks, cut at capacity
        if (bad_cnt != 3'd0)
        begin
            if (!stop)
            begin
                if (room3 >= bad_cnt)
                    n = bad_cnt;
                else
                begin
                    n    = room3;
                    stop = 1'b1;
                end
            end
        end
        for (int i = 0; i < MAX_GROUP; i++)
        begin
            if (3'(i) < n)
                group.units[i] = UNIT_QMARK;
        end

        if (want_single)
        begin
            if (stop || room3 == 3'd0)
                stop = 1'b1;
            else
            begin
                group.units[0] = code[15:0];
                n              = 3'd1;
            end
        end

        if (want_pair)
        begin
            if (stop || room3 < 3'd2)
                stop = 1'b1;
            else
            begin
                group.units[0] = HI_SURR_BASE + 16'(code_off[19:10]);
                group.units[1] = LO_SURR_BASE + 16'(code[9:0]);
                n              = 3'd2;
            end
        end

        if (want_fresh)
        begin
            if (stop)
                st_next.needed = 3'd0;
            if (text_byte == 8'h00)
            begin
                group.units[n[1:0]] = UNIT_TERM;
                n                   = n + 3'd1;
            end
            else if (stop || room3 <= n)
                stop = 1'b1;
            else if (text_byte < 8'h80)
            begin
                group.units[n[1:0]] = {8'h00, text_byte};
                n                   = n + 3'd1;
            end
            else if (text_byte inside {[8'hC2:8'hDF]})
            begin
                st_next.needed  = 3'd2;
                st_next.seen    = 2'd0;
                st_next.partial = 21'(text_byte[4:0]);
            end
            else if (text_byte inside {[8'hE0:8'hEF]})
            begin
                st_next.needed  = 3'd3;
                st_next.seen    = 2'd0;
                st_next.partial = 21'(text_byte[3:0]);
            end
            else if (text_byte inside {[8'hF0:8'hF4]})
            begin
                st_next.needed  = 3'd4;
                st_next.seen    = 2'd0;
                st_next.partial = 21'(text_byte[2:0]);
            end
            else
            begin
                group.units[n[1:0]] = UNIT_QMARK;
                n                   = n + 3'd1;
            end
        end

        st_next.stopped = stop;
        group.count     = n;

        if (want_fresh && text_byte == 8'h00)
        begin
            // terminator does not count against capacity; next string starts clean
            st_next = '0;
            uw_next = '0;
        end
        else
            uw_next = uw + UW'(n);
    end

endmodule

// ===== src/utf8_to_utf16_strict_decoder.sv =====
// latency: first code unit of a byte is offered in the cycle after the byte transfer
// throughput: one byte per cycle while each byte yields at most one code unit and unit_stall is low
// a byte yielding k units (up to 4) holds the input until the last of them transfers;
// the unit buffer drains one unit per cycle on the output port while unit_stall is low
// reset: rst_n clears decode state, units-written count, buffer count and index; capacity returns to 4095
module utf8_to_utf16_strict_decoder
    import u8u16_pkg::*;
#(
    parameter int unsigned MAX_UNITS = MAX_UNITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             text_valid,
    output logic             text_stall,
    input  logic [7:0]       text_byte,
    output logic             unit_valid,
    input  logic             unit_stall,
    output logic [15:0]      code_unit,
    output logic             last
);

`include "utf8_to_utf16_strict_decoder_macros.svh"

    localparam int unsigned UW  = $clog2(MAX_UNITS);
    localparam logic [16:0] LIM = 17'(MAX_UNITS - 1);

    logic [CAP_W-1:0] cap_reg;
    dec_state_t       state_reg, state_next;
    logic [UW-1:0]    uw_reg, uw_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [1:0]       idx_reg, idx_next;
    logic [MAX_GROUP-1:0][15:0] units_reg;

    logic [16:0]   cap_wide;
    logic [UW-1:0] cap_eff;
    unit_group_t   group;
    logic          text_xfer;
    logic          unit_xfer;

    assign cap_wide = 17'(cap_reg);
    assign cap_eff  = (cap_wide < LIM) ? cap_wide[UW-1:0] : LIM[UW-1:0];

    u8u16_step #(
        .UW (UW)
    ) u_step (
        .st        (state_reg),
        .uw        (uw_reg),
        .cap       (cap_eff),
        .text_byte (text_byte),
        .st_next   (state_next),
        .uw_next   (uw_next),
        .group     (group)
    );

    assign unit_valid = (cnt_reg != 3'd0);
    assign code_unit  = units_reg[idx_reg];
    assign last       = (3'(idx_reg) + 3'd1 == cnt_reg);
    assign unit_xfer  = unit_valid && !unit_stall;
    assign text_stall = unit_valid && !(unit_xfer && last);
    assign text_xfer  = text_valid && !text_stall;

    // unit buffer control
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (text_xfer)
        begin
            cnt_next = group.count;
            idx_next = 2'd0;
        end
        else if (unit_xfer)
        begin
            if (last)
            begin
                cnt_next = 3'd0;
                idx_next = 2'd0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            state_reg <= '0;
            uw_reg    <= '0;
            cnt_reg   <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (text_xfer)
            begin
                state_reg <= state_next;
                uw_reg    <= uw_next;
            end
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_xfer)
            units_reg <= group.units;
    end

    `U8U16_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= 3'd4, "unit count above four")
    `U8U16_ASSERT_ALWAYS(a_uw_limit, 17'(uw_reg) <= LIM, "units written above limit")
    `U8U16_ASSERT_ALWAYS(a_open_not_stopped,
        (state_reg.needed == 3'd0) || !state_reg.stopped, "sequence open after stop")
    `U8U16_ASSERT_ALWAYS(a_accept_empty,
        !text_xfer || cnt_reg == 3'd0 || (unit_xfer && last), "transfer over pending units")
    `U8U16_ASSERT_NEXT(a_term_clears, text_xfer && text_byte == 8'h00,
        uw_reg == '0 && state_reg == '0 && cnt_reg != 3'd0, "terminator did not clear state")

endmodule
